@@ hw/rtl/bfa_pkg.sv @@
// Shared constants for the bitmap frame allocator.
// No dependencies.
`timescale 1ns / 1ps

package bfa_pkg;

    localparam logic [1:0] OP_ALLOC_ONE = 2'd0;
    localparam logic [1:0] OP_FREE_ONE  = 2'd1;
    localparam logic [1:0] OP_ALLOC_RUN = 2'd2;
    localparam logic [1:0] OP_FREE_RUN  = 2'd3;

    localparam logic [0:0] REG_FIRST_FREE  = 1'b0;
    localparam logic [0:0] REG_FRAME_COUNT = 1'b1;

    localparam int ADDR_W = 27;
    localparam int CNT_W  = 16;

endpackage

@@ hw/rtl/bfa_ram.sv @@
// Generic single-port synchronous RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps

module bfa_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

@@ hw/rtl/bitmap_frame_allocator.sv @@
// Bitmap first-fit frame allocator: one request at a time, one map frame per cycle.
// An allocation scans the map for a free run and marks it if one is found; a free
// clears the addressed run inside the managed frames. Each request then recounts
// the managed frames to produce the used-frame count, and the result waits for
// the previous beat to leave the output register. After reset a clearing pass
// over all MAP_FRAMES map entries runs before the first request is accepted.
// Uses bfa_pkg and bfa_ram.
`timescale 1ns / 1ps

module bitmap_frame_allocator #(
    parameter int FRAME_SHIFT = 12,
    parameter int MAP_FRAMES  = 32768
) (
    input  logic        clk,
    input  logic        rst_n,
    // APB configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // request: op[1:0], phys_address[28:2], byte_length[55:29]
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,
    // result: status[0], frame_address[27:1], used_frames[43:28]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata
);

    localparam int IW = $clog2(MAP_FRAMES);
    localparam int CW = IW + 1;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_SCAN  = 3'd2;
    localparam logic [2:0] ST_MARK  = 3'd3;
    localparam logic [2:0] ST_FREE  = 3'd4;
    localparam logic [2:0] ST_COUNT = 3'd5;
    localparam logic [2:0] ST_OUT   = 3'd6;

    logic [15:0] first_free_reg, frame_count_reg;
    logic [2:0]  state_reg;
    logic [CW-1:0] idx_reg;      // scan/sweep pointer
    logic [CW-1:0] run_reg;      // current free run length / start
    logic [CW-1:0] end_reg;      // end (exclusive) of mark or free range
    logic          rd_pend_reg;  // a read is in flight for idx_reg-1
    logic [CW:0]   need_reg;
    logic [15:0]   used_reg;
    logic          status_reg;
    logic [26:0]   faddr_reg;
    logic          out_valid_reg;
    logic [47:0]   m_data_reg;

    logic [CW-1:0] tc, rs;
    always_comb
    begin
        tc = (32'(frame_count_reg) >= 32'(MAP_FRAMES))
             ? CW'(MAP_FRAMES) : CW'(frame_count_reg);
        rs = (32'(first_free_reg) < 32'(tc)) ? CW'(first_free_reg) : tc;
    end

    // config port
    assign pready = 1'b1;
    always_comb
    begin
        unique case (paddr[2])
            bfa_pkg::REG_FIRST_FREE: prdata = {16'd0, first_free_reg};
            default:                 prdata = {16'd0, frame_count_reg};
        endcase
    end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_free_reg  <= '0;
            frame_count_reg <= '0;
        end
        else if (psel && penable && pwrite && paddr[1:0] == 2'd0)
        begin
            if (paddr[2] == bfa_pkg::REG_FIRST_FREE)
                first_free_reg <= pwdata[15:0];
            else
                frame_count_reg <= pwdata[15:0];
        end
    end

    // map memory
    logic          ram_we, ram_wd, ram_rd;
    logic [IW-1:0] ram_addr;
    bfa_ram #(.WIDTH(1), .DEPTH(MAP_FRAMES)) u_map (
        .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wd), .rdata(ram_rd)
    );

    logic [CW-1:0] prev_idx;
    assign prev_idx = idx_reg - CW'(1);

    always_comb
    begin
        ram_we   = 1'b0;
        ram_wd   = 1'b0;
        ram_addr = idx_reg[IW-1:0];
        unique case (state_reg)
            ST_CLEAR: ram_we = 1'b1;
            ST_MARK:
            begin
                ram_we = (run_reg < end_reg);
                ram_wd = 1'b1;
                ram_addr = run_reg[IW-1:0];
            end
            ST_FREE:
            begin
                ram_we = (run_reg < end_reg) && (run_reg >= rs);
                ram_addr = run_reg[IW-1:0];
            end
            default: ;
        endcase
    end

    // input decode
    logic [1:0]    in_op;
    logic [26:0]   in_addr, in_len;
    assign in_op   = s_tdata[1:0];
    assign in_addr = s_tdata[28:2];
    assign in_len  = s_tdata[55:29];

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = m_data_reg;

    logic [27-FRAME_SHIFT:0] in_need;
    assign in_need = {1'b0, in_len[26:FRAME_SHIFT]} + 1'b1;

    logic [26:0] start_addr;
    assign start_addr = 27'(64'(run_reg) << FRAME_SHIFT);

    // result leaves the working registers when the output slot is free
    logic out_load;
    assign out_load = (state_reg == ST_OUT) && (!out_valid_reg || m_tready);

    // output beat valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            idx_reg       <= '0;
            run_reg       <= '0;
            end_reg       <= '0;
            rd_pend_reg   <= 1'b0;
            need_reg      <= '0;
            used_reg      <= '0;
            status_reg    <= 1'b0;
            faddr_reg     <= '0;
            m_data_reg    <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_CLEAR:
                begin
                    idx_reg <= idx_reg + CW'(1);
                    if (idx_reg == CW'(MAP_FRAMES - 1))
                        state_reg <= ST_IDLE;
                end
                ST_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        status_reg  <= 1'b0;
                        faddr_reg   <= '0;
                        rd_pend_reg <= 1'b0;
                        if (in_op[0] == 1'b0)
                        begin
                            need_reg  <= (in_op == bfa_pkg::OP_ALLOC_ONE) ? (CW+1)'(1)
                                        : ((28'(in_need) > 28'(MAP_FRAMES))
                                           ? (CW+1)'(MAP_FRAMES + 1)
                                           : (CW+1)'(in_need));
                            idx_reg   <= rs;
                            run_reg   <= '0;
                            state_reg <= ST_SCAN;
                        end
                        else
                        begin
                            if ((in_addr >> FRAME_SHIFT) < 27'(tc))
                            begin
                                run_reg <= CW'(in_addr >> FRAME_SHIFT);
                                if (in_op == bfa_pkg::OP_FREE_ONE)
                                    end_reg <= CW'(in_addr >> FRAME_SHIFT) + CW'(1);
                                else if (29'(in_addr >> FRAME_SHIFT) + 29'(in_need)
                                         > 29'(tc))
                                    end_reg <= tc;
                                else
                                    end_reg <= CW'(in_addr >> FRAME_SHIFT)
                                               + CW'(in_need);
                                state_reg <= ST_FREE;
                            end
                            else
                            begin
                                idx_reg   <= rs;
                                used_reg  <= 16'(rs);
                                state_reg <= ST_COUNT;
                            end
                        end
                    end
                end
                ST_SCAN:
                begin
                    // issue read at idx_reg, evaluate data of idx_reg-1
                    if (rd_pend_reg && !ram_rd &&
                        ((CW+1)'(run_reg) + (CW+1)'(1) == need_reg))
                    begin
                        run_reg   <= prev_idx + CW'(1) - CW'(need_reg);
                        end_reg   <= idx_reg;
                        state_reg <= ST_MARK;
                    end
                    else if (rd_pend_reg && !ram_rd)
                        run_reg <= run_reg + CW'(1);
                    else if (rd_pend_reg)
                        run_reg <= '0;
                    if (!(rd_pend_reg && !ram_rd &&
                          ((CW+1)'(run_reg) + (CW+1)'(1) == need_reg)))
                    begin
                        if (idx_reg < tc)
                        begin
                            idx_reg     <= idx_reg + CW'(1);
                            rd_pend_reg <= 1'b1;
                        end
                        else
                        begin
                            status_reg  <= 1'b1;
                            idx_reg     <= rs;
                            used_reg    <= 16'(rs);
                            rd_pend_reg <= 1'b0;
                            state_reg   <= ST_COUNT;
                        end
                    end
                end
                ST_MARK:
                begin
                    if (run_reg == end_reg - CW'(need_reg))
                        faddr_reg <= start_addr;
                    if (run_reg < end_reg)
                        run_reg <= run_reg + CW'(1);
                    else
                    begin
                        idx_reg     <= rs;
                        used_reg    <= 16'(rs);
                        rd_pend_reg <= 1'b0;
                        state_reg   <= ST_COUNT;
                    end
                end
                ST_FREE:
                begin
                    if (run_reg < end_reg)
                        run_reg <= run_reg + CW'(1);
                    else
                    begin
                        idx_reg     <= rs;
                        used_reg    <= 16'(rs);
                        rd_pend_reg <= 1'b0;
                        state_reg   <= ST_COUNT;
                    end
                end
                ST_COUNT:
                begin
                    if (rd_pend_reg && ram_rd)
                        used_reg <= used_reg + 16'd1;
                    if (idx_reg < tc)
                    begin
                        idx_reg     <= idx_reg + CW'(1);
                        rd_pend_reg <= 1'b1;
                    end
                    else
                    begin
                        rd_pend_reg <= 1'b0;
                        state_reg   <= ST_OUT;
                    end
                end
                ST_OUT:
                begin
                    if (out_load)
                    begin
                        m_data_reg <= {4'd0, used_reg, faddr_reg, status_reg};
                        state_reg  <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule
